FILE: rtl/j1939_gnss_frame_decoder_assert.svh
// ----------------------------------------------------------------------------
// J1939 GNSS frame decoder assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef J1939_GNSS_FRAME_DECODER_ASSERT_SVH
`define J1939_GNSS_FRAME_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JGFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jgfd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define JGFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jgfd assertion failed");

`endif

FILE: rtl/jgfd_pkg.sv
// ----------------------------------------------------------------------------
// J1939 GNSS frame decoder package
// Field widths, update kinds, PGN codes and decode limits.
// ----------------------------------------------------------------------------
package jgfd_pkg;

  // Field widths
  localparam int ID_W   = 29;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int KIND_W = 3;
  localparam int SA_W   = 8;
  localparam int FLAG_W = 5;

  // Update kind reported with every result
  typedef enum logic [KIND_W-1:0] {
    KIND_IGNORED  = 3'd0,
    KIND_POSITION = 3'd1,
    KIND_TIME     = 3'd2,
    KIND_ALTITUDE = 3'd3,
    KIND_HEADING  = 3'd4,
    KIND_SPEED    = 3'd5,
    KIND_REJECTED = 3'd6
  } kind_t;

  typedef logic [FLAG_W-1:0] flags_t;

  // Valid flag bit positions
  localparam int FLAG_POSITION = 0;
  localparam int FLAG_TIME     = 1;
  localparam int FLAG_ALTITUDE = 2;
  localparam int FLAG_HEADING  = 3;
  localparam int FLAG_SPEED    = 4;

  // PGN extraction
  localparam logic [17:0] PGN_POSITION  = 18'h0FEF3;
  localparam logic [17:0] PGN_TIME      = 18'h0FEF0;
  localparam logic [17:0] PGN_ALTITUDE  = 18'h0FEF2;
  localparam logic [17:0] PGN_HEADING   = 18'h0FE45;
  localparam logic [17:0] PGN_SPEED     = 18'h0FEF1;
  localparam logic [17:0] PDU1_PGN_MASK = 18'h3FF00;
  localparam logic [7:0]  PF_PDU2_MIN   = 8'hF0;

  // Minimum data lengths
  localparam logic [LEN_W-1:0] LEN_POSITION = 4'd8;
  localparam logic [LEN_W-1:0] LEN_TIME     = 4'd4;
  localparam logic [LEN_W-1:0] LEN_ALTITUDE = 4'd4;
  localparam logic [LEN_W-1:0] LEN_HEADING  = 4'd2;
  localparam logic [LEN_W-1:0] LEN_SPEED    = 4'd3;

  // Not-available codes
  localparam logic [31:0] NA_COORD = 32'h7FFF_FFFF;
  localparam logic [31:0] NA_U32   = 32'hFFFF_FFFF;
  localparam logic [15:0] NA_U16   = 16'hFFFF;

  // Range limits
  localparam logic signed [31:0] LAT_MAX = 32'sd900000000;
  localparam logic signed [31:0] LAT_MIN = -32'sd900000000;
  localparam logic signed [31:0] LON_MAX = 32'sd1800000000;
  localparam logic signed [31:0] LON_MIN = -32'sd1800000000;
  localparam logic [7:0]  HOUR_MAX   = 8'd23;
  localparam logic [7:0]  MINUTE_MAX = 8'd59;
  localparam logic [15:0] MILLIS_MAX = 16'd59999;

  // Receiver source address after reset
  localparam logic [SA_W-1:0] RSA_RESET = 8'd28;

endpackage

FILE: rtl/jgfd_if.sv
// ----------------------------------------------------------------------------
// J1939 GNSS frame decoder channels
// Valid/ready channels for CAN frames in and decoded snapshots out.
// ----------------------------------------------------------------------------

// CAN frame request channel
interface jgfd_frame_if import jgfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_extended;
  logic [ID_W-1:0]   identifier;
  logic [LEN_W-1:0]  data_length;
  logic [DATA_W-1:0] payload;

  modport source (output valid, is_extended, identifier, data_length, payload,
                  input ready);
  modport sink   (input valid, is_extended, identifier, data_length, payload,
                  output ready);
endinterface

// Decode result channel
interface jgfd_result_if import jgfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  update_kind;
  logic signed [30:0] latitude_raw;
  logic signed [31:0] longitude_raw;
  logic [4:0]         hour_of_day;
  logic [5:0]         minute_of_hour;
  logic [15:0]        millis_of_minute;
  logic [31:0]        altitude_raw;
  logic [15:0]        heading_raw;
  logic [15:0]        speed_raw;
  logic [FLAG_W-1:0]  valid_flags;

  modport source (output valid, update_kind, latitude_raw, longitude_raw, hour_of_day,
                  minute_of_hour, millis_of_minute, altitude_raw, heading_raw,
                  speed_raw, valid_flags,
                  input ready);
  modport sink   (input valid, update_kind, latitude_raw, longitude_raw, hour_of_day,
                  minute_of_hour, millis_of_minute, altitude_raw, heading_raw,
                  speed_raw, valid_flags,
                  output ready);
endinterface

FILE: rtl/j1939_gnss_frame_decoder.sv
// ----------------------------------------------------------------------------
// J1939 GNSS frame decoder
// Decodes position, time, altitude, heading and wheel speed PGNs from CAN
// frames into a latched snapshot of raw scaled values with valid flags.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake      | payload
//  ---------+-----------+----------------+----------------------------------
//  in_if    | in        | valid / ready  | is_extended, identifier, length,
//           |           |                | payload bytes
//  out_if   | out       | valid / ready  | update kind + full snapshot
//  cfg_*    | in        | write enable   | receiver source address
//
// One frame per cycle if not stalled; results appear in the cycle after the
// request is taken, from the result register fed by the single decode stage.
// Reset clears the snapshot and all valid flags; source address returns to 28.
// A stalled result holds; a new frame is taken in the cycle the pending
// result leaves, so the output register alone sets the throughput.
// ----------------------------------------------------------------------------
`include "j1939_gnss_frame_decoder_assert.svh"

module j1939_gnss_frame_decoder import jgfd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [SA_W-1:0] cfg_wdata,
  jgfd_frame_if.sink      in_if,
  jgfd_result_if.source   out_if
);

  // Registers
  logic [SA_W-1:0] rsa_r;
  logic            out_valid_r;
  kind_t           kind_r,    kind_nxt;
  logic [30:0]     lat_r,     lat_nxt;
  logic [31:0]     lon_r,     lon_nxt;
  logic [4:0]      hour_r,    hour_nxt;
  logic [5:0]      minute_r,  minute_nxt;
  logic [15:0]     millis_r,  millis_nxt;
  logic [31:0]     alt_r,     alt_nxt;
  logic [15:0]     heading_r, heading_nxt;
  logic [15:0]     speed_r,   speed_nxt;
  flags_t          valid_r,   valid_nxt;

  // Frame fields
  logic        in_fire;
  logic [7:0]  src_addr;
  logic [7:0]  pdu_format;
  logic [17:0] pgn_raw;
  logic [17:0] pgn;
  logic [31:0] lat_word;
  logic [31:0] lon_word;
  logic [15:0] ms_word;
  logic [7:0]  min_byte;
  logic [7:0]  hour_byte;
  logic [15:0] speed_word;
  logic        lat_ok;
  logic        lon_ok;

  // Take a new request whenever the result register is free or draining
  assign in_fire     = in_if.valid && in_if.ready;
  assign in_if.ready = !out_valid_r || out_if.ready;

  // Split identifier and payload
  assign src_addr   = in_if.identifier[7:0];
  assign pdu_format = in_if.identifier[23:16];
  assign pgn_raw    = in_if.identifier[25:8];
  assign pgn        = (pdu_format >= PF_PDU2_MIN) ? pgn_raw : (pgn_raw & PDU1_PGN_MASK);
  assign lat_word   = in_if.payload[31:0];
  assign lon_word   = in_if.payload[63:32];
  assign ms_word    = in_if.payload[15:0];
  assign min_byte   = in_if.payload[23:16];
  assign hour_byte  = in_if.payload[31:24];
  assign speed_word = in_if.payload[23:8];

  // Signed range checks on coordinates
  assign lat_ok = ($signed(lat_word) <= LAT_MAX) && ($signed(lat_word) >= LAT_MIN);
  assign lon_ok = ($signed(lon_word) <= LON_MAX) && ($signed(lon_word) >= LON_MIN);

  // Decode one frame against the current snapshot
  always_comb begin
    kind_nxt    = KIND_IGNORED;
    lat_nxt     = lat_r;
    lon_nxt     = lon_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    millis_nxt  = millis_r;
    alt_nxt     = alt_r;
    heading_nxt = heading_r;
    speed_nxt   = speed_r;
    valid_nxt   = valid_r;
    if (in_if.is_extended) begin
      if (pgn == PGN_SPEED) begin
        if (in_if.data_length < LEN_SPEED || speed_word == NA_U16) begin
          kind_nxt = KIND_REJECTED;
        end else begin
          kind_nxt              = KIND_SPEED;
          speed_nxt             = speed_word;
          valid_nxt[FLAG_SPEED] = 1'b1;
        end
      end else if (src_addr == rsa_r) begin
        if (pgn == PGN_POSITION) begin
          if (in_if.data_length < LEN_POSITION || lat_word == NA_COORD ||
              lon_word == NA_COORD || !lat_ok || !lon_ok) begin
            kind_nxt = KIND_REJECTED;
          end else begin
            kind_nxt                 = KIND_POSITION;
            lat_nxt                  = lat_word[30:0];
            lon_nxt                  = lon_word;
            valid_nxt[FLAG_POSITION] = 1'b1;
          end
        end else if (pgn == PGN_TIME) begin
          if (in_if.data_length < LEN_TIME || hour_byte > HOUR_MAX ||
              min_byte > MINUTE_MAX || ms_word > MILLIS_MAX) begin
            kind_nxt = KIND_REJECTED;
          end else begin
            kind_nxt             = KIND_TIME;
            hour_nxt             = hour_byte[4:0];
            minute_nxt           = min_byte[5:0];
            millis_nxt           = ms_word;
            valid_nxt[FLAG_TIME] = 1'b1;
          end
        end else if (pgn == PGN_ALTITUDE) begin
          if (in_if.data_length < LEN_ALTITUDE || lat_word == NA_U32) begin
            kind_nxt = KIND_REJECTED;
          end else begin
            kind_nxt                 = KIND_ALTITUDE;
            alt_nxt                  = lat_word;
            valid_nxt[FLAG_ALTITUDE] = 1'b1;
          end
        end else if (pgn == PGN_HEADING) begin
          if (in_if.data_length < LEN_HEADING || ms_word == NA_U16) begin
            kind_nxt = KIND_REJECTED;
          end else begin
            kind_nxt                = KIND_HEADING;
            heading_nxt             = ms_word;
            valid_nxt[FLAG_HEADING] = 1'b1;
          end
        end
      end
    end
  end

  // Hold config, snapshot and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsa_r       <= RSA_RESET;
      out_valid_r <= 1'b0;
      kind_r      <= KIND_IGNORED;
      lat_r       <= '0;
      lon_r       <= '0;
      hour_r      <= '0;
      minute_r    <= '0;
      millis_r    <= '0;
      alt_r       <= '0;
      heading_r   <= '0;
      speed_r     <= '0;
      valid_r     <= '0;
    end else begin
      if (cfg_we) begin
        rsa_r <= cfg_wdata;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
        kind_r      <= kind_nxt;
        lat_r       <= lat_nxt;
        lon_r       <= lon_nxt;
        hour_r      <= hour_nxt;
        minute_r    <= minute_nxt;
        millis_r    <= millis_nxt;
        alt_r       <= alt_nxt;
        heading_r   <= heading_nxt;
        speed_r     <= speed_nxt;
        valid_r     <= valid_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Drive the result channel straight from the snapshot registers
  assign out_if.valid            = out_valid_r;
  assign out_if.update_kind      = kind_r;
  assign out_if.latitude_raw     = $signed(lat_r);
  assign out_if.longitude_raw    = $signed(lon_r);
  assign out_if.hour_of_day      = hour_r;
  assign out_if.minute_of_hour   = minute_r;
  assign out_if.millis_of_minute = millis_r;
  assign out_if.altitude_raw     = alt_r;
  assign out_if.heading_raw      = heading_r;
  assign out_if.speed_raw        = speed_r;
  assign out_if.valid_flags      = valid_r;

  // Checks
  `JGFD_ASSERT_NEXT(a_flags_sticky, clk, rst_n, 1'b1, (valid_r & $past(valid_r)) == $past(valid_r))
  `JGFD_ASSERT_NEXT(a_std_ignored, clk, rst_n, in_fire && !in_if.is_extended, kind_r == KIND_IGNORED)
  `JGFD_ASSERT_NEXT(a_reject_holds, clk, rst_n, in_fire && kind_nxt == KIND_REJECTED, $stable(valid_r) && $stable(lat_r) && $stable(speed_r))
  `JGFD_ASSERT_SAME(a_speed_flag, clk, rst_n, out_valid_r && kind_r == KIND_SPEED, valid_r[FLAG_SPEED])

endmodule
